@@ rtl/whra_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whra_pkg: shared types and constants for the windowed heart-rate average
// Beat and result payload structs, command and run-mode codes, bpm scale.
// ----------------------------------------------------------------------------
package whra_pkg;

  // Command codes carried in the func field
  typedef enum logic [1:0] {
    FN_BEAT   = 2'd0,
    FN_START  = 2'd1,
    FN_CANCEL = 2'd2,
    FN_RESET  = 2'd3
  } func_e;

  // Run mode as reported on the result
  typedef enum logic [1:0] {
    MODE_IDLE       = 2'd0,
    MODE_COLLECTING = 2'd1,
    MODE_CANCELLED  = 2'd2,
    MODE_DONE       = 2'd3
  } run_mode_e;

  // 60000 ms per minute times 256 for the 16.8 format
  localparam logic [23:0] BPM_SCALE   = 24'd15360000;
  localparam logic [23:0] BPM_MAX     = 24'hFFFFFF;
  localparam logic [31:0] WINDOW_RST  = 32'd15000;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] timestamp;
  } whra_in_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [23:0] bpm_q8;
    logic [6:0]  intervals_counted;
    logic        zero_total;
  } whra_out_t;

endpackage

@@ rtl/windowed_heart_rate_average.sv @@
`timescale 1ns / 1ps
// An accepted item's result is registered and shows in the cycle after it is
// taken, except for a beat that ends a run with intervals and a non-zero sum,
// which passes SQ_MUL, SQ_ADD, SQ_DIV (bit-serial restoring divider, one bit a
// cycle) and SQ_WB. Throughput: one item per cycle for plain beats and commands;
// none is taken while that sequence runs or while the result register is full.
// Reset (rst_ni low) clears run state and output valid, and sets a 15000 ms window.
// ----------------------------------------------------------------------------
// windowed_heart_rate_average
// Averages beat intervals over a time window and reports bpm in 16.8 format.
// ----------------------------------------------------------------------------
module windowed_heart_rate_average #(
  parameter int unsigned INTERVAL_LIMIT = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  whra_pkg::whra_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output whra_pkg::whra_out_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i
);
  import whra_pkg::*;

  localparam int unsigned TALLY_W = $clog2(INTERVAL_LIMIT + 1);
  localparam int unsigned EXT_W   = (TALLY_W > 7) ? TALLY_W : 7;
  localparam int unsigned NUM_W   = TALLY_W + 24;
  localparam int unsigned DVD_W   = ((NUM_W > 32) ? NUM_W : 32) + 1;
  localparam int unsigned CNT_W   = $clog2(DVD_W);

  // Sequencer states
  typedef enum logic [4:0] {
    SQ_IDLE = 5'b00001,
    SQ_MUL  = 5'b00010,
    SQ_ADD  = 5'b00100,
    SQ_DIV  = 5'b01000,
    SQ_WB   = 5'b10000
  } seq_state_e;

  seq_state_e seq_q, seq_d;

  // Architectural run state
  logic [31:0]        window_q;
  run_mode_e          mode_q, mode_d;
  logic               anchored_q, anchored_d;
  logic [31:0]        begin_q, begin_d;
  logic [31:0]        prev_q, prev_d;
  logic [TALLY_W-1:0] tally_q, tally_d;
  logic [31:0]        sum_q, sum_d;
  logic [23:0]        bpm_q, bpm_d;
  logic               zflag_q, zflag_d;

  // Divider datapath
  logic [NUM_W-1:0]   prod_q;
  logic [DVD_W-1:0]   dq_q, dq_d;
  logic [31:0]        rem_q, rem_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  // Output register
  logic               out_valid_q, out_valid_d;
  whra_out_t          out_data_q, out_data_d;

  logic               slot_free;
  logic               accept;
  logic               need_div;
  logic [31:0]        elapsed;
  logic [31:0]        gap;
  logic [32:0]        sum_add;
  logic [32:0]        rem_sh;
  logic               rem_ge;
  logic [EXT_W-1:0]   tally_wide;
  logic [EXT_W-1:0]   tally_wide_q;
  logic [23:0]        bpm_sat;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (seq_q == SQ_IDLE) && slot_free;
  assign accept     = in_valid_i && in_ready_o;

  assign elapsed = in_data_i.timestamp - begin_q;
  assign gap     = in_data_i.timestamp - prev_q;
  assign sum_add = {1'b0, sum_q} + {1'b0, gap};

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_sh = {rem_q, dq_q[DVD_W-1]};
  assign rem_ge = rem_sh >= {1'b0, sum_q};

  // Quotient saturation to 24 bits
  assign bpm_sat = (|dq_q[DVD_W-1:24]) ? BPM_MAX : dq_q[23:0];

  assign tally_wide   = EXT_W'(tally_d);
  assign tally_wide_q = EXT_W'(tally_q);

  // Step logic for one accepted item, and the bpm update when the divider ends
  always_comb begin
    mode_d     = mode_q;
    anchored_d = anchored_q;
    begin_d    = begin_q;
    prev_d     = prev_q;
    tally_d    = tally_q;
    sum_d      = sum_q;
    bpm_d      = bpm_q;
    zflag_d    = zflag_q;
    need_div   = 1'b0;
    if (accept) begin
      unique case (func_e'(in_data_i.func))
        FN_BEAT: begin
          if (mode_q == MODE_COLLECTING) begin
            if (!anchored_q) begin
              anchored_d = 1'b1;
              begin_d    = in_data_i.timestamp;
              prev_d     = in_data_i.timestamp;
            end else if (elapsed >= window_q) begin
              // window closed: this beat is not counted
              mode_d = MODE_DONE;
              if (tally_q == '0) begin
                bpm_d   = '0;
                zflag_d = 1'b0;
              end else if (sum_q == '0) begin
                bpm_d   = BPM_MAX;
                zflag_d = 1'b1;
              end else begin
                need_div = 1'b1;
              end
            end else begin
              if (tally_q < TALLY_W'(INTERVAL_LIMIT)) begin
                sum_d   = sum_add[32] ? '1 : sum_add[31:0];
                tally_d = tally_q + TALLY_W'(1);
              end
              prev_d = in_data_i.timestamp;
            end
          end
        end
        FN_START: begin
          if (mode_q == MODE_IDLE) mode_d = MODE_COLLECTING;
        end
        FN_CANCEL: begin
          if (mode_q == MODE_COLLECTING) mode_d = MODE_CANCELLED;
        end
        FN_RESET: begin
          mode_d     = MODE_IDLE;
          anchored_d = 1'b0;
          begin_d    = '0;
          prev_d     = '0;
          tally_d    = '0;
          sum_d      = '0;
          bpm_d      = '0;
          zflag_d    = 1'b0;
        end
        default: ;
      endcase
    end else if (seq_q == SQ_DIV && cnt_q == '0) begin
      // last quotient bit lands this cycle; result is taken in SQ_WB
      bpm_d   = bpm_q;
      zflag_d = 1'b0;
    end else if (seq_q == SQ_WB) begin
      bpm_d   = bpm_sat;
      zflag_d = 1'b0;
    end
  end

  // Sequencer and divider control
  always_comb begin
    seq_d       = seq_q;
    dq_d        = dq_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    unique case (seq_q)
      SQ_IDLE: begin
        if (accept) begin
          if (need_div) begin
            seq_d = SQ_MUL;
          end else begin
            out_valid_d                  = 1'b1;
            out_data_d.mode              = mode_d;
            out_data_d.bpm_q8            = bpm_d;
            out_data_d.intervals_counted = tally_wide[6:0];
            out_data_d.zero_total        = zflag_d;
          end
        end
      end
      SQ_MUL: begin
        seq_d = SQ_ADD;
      end
      SQ_ADD: begin
        // dividend = scale * count + sum / 2, for round to nearest
        dq_d  = DVD_W'(prod_q) + DVD_W'(sum_q[31:1]);
        rem_d = '0;
        cnt_d = CNT_W'(DVD_W - 1);
        seq_d = SQ_DIV;
      end
      SQ_DIV: begin
        rem_d = rem_ge ? 32'(rem_sh - {1'b0, sum_q}) : rem_sh[31:0];
        dq_d  = {dq_q[DVD_W-2:0], rem_ge};
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) seq_d = SQ_WB;
      end
      SQ_WB: begin
        if (slot_free) begin
          out_valid_d                  = 1'b1;
          out_data_d.mode              = mode_q;
          out_data_d.bpm_q8            = bpm_sat;
          out_data_d.intervals_counted = tally_wide_q[6:0];
          out_data_d.zero_total        = 1'b0;
          seq_d                        = SQ_IDLE;
        end
      end
      default: seq_d = SQ_IDLE;
    endcase
  end

  // Control and run state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= SQ_IDLE;
      window_q    <= WINDOW_RST;
      mode_q      <= MODE_IDLE;
      anchored_q  <= 1'b0;
      begin_q     <= '0;
      prev_q      <= '0;
      tally_q     <= '0;
      sum_q       <= '0;
      bpm_q       <= '0;
      zflag_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      seq_q       <= seq_d;
      mode_q      <= mode_d;
      anchored_q  <= anchored_d;
      begin_q     <= begin_d;
      prev_q      <= prev_d;
      tally_q     <= tally_d;
      sum_q       <= sum_d;
      zflag_q     <= zflag_d;
      out_valid_q <= out_valid_d;
      if (seq_q == SQ_WB && !slot_free) bpm_q <= bpm_q;
      else bpm_q <= bpm_d;
      if (cfg_we_i) window_q <= cfg_wdata_i;
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    prod_q     <= NUM_W'(tally_q) * NUM_W'(BPM_SCALE);
    dq_q       <= dq_d;
    rem_q      <= rem_d;
    cnt_q      <= cnt_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for windowed_heart_rate_average
// Sends command and beat items over valid/ready with random idling on both
// sides, predicts the result of every accepted item and compares it field by
// field. Runs through several window settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_top;
  import whra_pkg::*;

  localparam int unsigned TALLY_CAP    = 64;
  localparam int          STALL_LIMIT  = 4000;
  localparam int          DRAIN_WAIT   = 48;
  localparam int          RANDOM_ITEMS = 1500;
  localparam int          N_PHASES     = 8;

  // Expected-result store with its own copy of the run state
  class bpm_scoreboard;
    logic [31:0] window_len;
    run_mode_e   mode;
    bit          anchored;
    logic [31:0] anchor_ts;
    logic [31:0] last_ts;
    logic [6:0]  tally;
    logic [31:0] interval_total;
    logic [23:0] bpm;
    bit          zero_total;
    whra_out_t   expected_readings[$];
    int          n_errors;

    function new();
      window_len = WINDOW_RST;
      n_errors   = 0;
      clear_run();
    endfunction

    function void clear_run();
      mode           = MODE_IDLE;
      anchored       = 1'b0;
      anchor_ts      = '0;
      last_ts        = '0;
      tally          = '0;
      interval_total = '0;
      bpm            = '0;
      zero_total     = 1'b0;
    endfunction

    // Window closed: rounded rate over the counted intervals, saturating
    function void close_window();
      logic [63:0] quotient;
      mode       = MODE_DONE;
      zero_total = 1'b0;
      if (tally == 0) begin
        bpm = '0;
      end else if (interval_total == 0) begin
        bpm        = BPM_MAX;
        zero_total = 1'b1;
      end else begin
        quotient = (64'(BPM_SCALE) * 64'(tally) + 64'(interval_total >> 1))
                   / 64'(interval_total);
        bpm = (quotient > 64'(BPM_MAX)) ? BPM_MAX : quotient[23:0];
      end
    endfunction

    function void apply_beat(logic [31:0] ts);
      logic [31:0] elapsed;
      logic [31:0] gap;
      logic [31:0] total;
      if (mode != MODE_COLLECTING) return;
      if (!anchored) begin
        anchored  = 1'b1;
        anchor_ts = ts;
        last_ts   = ts;
        return;
      end
      elapsed = ts - anchor_ts;
      if (elapsed >= window_len) begin
        close_window();
        return;
      end
      // once the tally is full the beat only moves the last timestamp
      if (tally < TALLY_CAP) begin
        gap            = ts - last_ts;
        total          = interval_total + gap;
        interval_total = (total < interval_total) ? '1 : total;
        tally++;
      end
      last_ts = ts;
    endfunction

    function void note_item(whra_in_t item);
      whra_out_t reading;
      case (func_e'(item.func))
        FN_BEAT:   apply_beat(item.timestamp);
        FN_START:  if (mode == MODE_IDLE) mode = MODE_COLLECTING;
        FN_CANCEL: if (mode == MODE_COLLECTING) mode = MODE_CANCELLED;
        default:   clear_run();
      endcase
      reading.mode              = mode;
      reading.bpm_q8            = bpm;
      reading.intervals_counted = tally;
      reading.zero_total        = zero_total;
      expected_readings.push_back(reading);
    endfunction

    task report(string msg);
      n_errors++;
      if (n_errors <= 40) $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    task check_reading(whra_out_t got);
      whra_out_t want;
      if (expected_readings.size() == 0) begin
        report($sformatf("result %h with nothing outstanding", got));
        return;
      end
      want = expected_readings.pop_front();
      if (got.mode !== want.mode)
        report($sformatf("mode got %0d want %0d", got.mode, want.mode));
      if (got.bpm_q8 !== want.bpm_q8)
        report($sformatf("bpm_q8 got %h want %h", got.bpm_q8, want.bpm_q8));
      if (got.intervals_counted !== want.intervals_counted)
        report($sformatf("intervals_counted got %0d want %0d",
                         got.intervals_counted, want.intervals_counted));
      if (got.zero_total !== want.zero_total)
        report($sformatf("zero_total got %0b want %0b", got.zero_total, want.zero_total));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  whra_in_t    in_data_i   = '0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  whra_out_t   out_data_o;
  logic        cfg_we_i    = 1'b0;
  logic [31:0] cfg_wdata_i = '0;

  bpm_scoreboard sb = new();
  int            items_sent     = 0;
  int            stalled_cycles = 0;
  bit            no_gaps        = 1'b0;
  logic [31:0]   window_setting = WINDOW_RST;

  windowed_heart_rate_average #(
    .INTERVAL_LIMIT(TALLY_CAP)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Beat-to-beat spacing in ms, mostly a plausible pulse
  function automatic logic [31:0] pick_interval();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(250, 2000);
    if (r < 78) return 0;
    if (r < 88) return $urandom_range(1, 249);
    if (r < 96) return $urandom_range(2001, 200000);
    return $urandom();
  endfunction

  // Valid is left high after each item so a back-to-back item needs no re-raise
  task automatic send_item(func_e f, logic [31:0] ts);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_data_i  <= '{func: f, timestamp: ts};
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    // let the monitor log the last accepted item before the queue is checked
    @(posedge clk_i);
    while (sb.expected_readings.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic set_window(logic [31:0] ms);
    drain();
    cfg_wdata_i <= ms;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    sb.window_len  = ms;
    window_setting = ms;
  endtask

  // One arm/anchor/collect run, ended by the window, a cancel or left open
  task automatic beat_session();
    int          kind;
    int          n_beats;
    int          i;
    logic [31:0] t0;
    logic [31:0] t;
    logic [31:0] step;
    logic [31:0] elapsed;
    bit          ended;
    kind = $urandom_range(0, 9);
    if ($urandom_range(0, 4) != 0) send_item(FN_RESET, $urandom());
    send_item(FN_START, $urandom());
    if ($urandom_range(0, 9) == 0) send_item(FN_START, $urandom());
    t0 = $urandom();
    t  = t0;
    send_item(FN_BEAT, t0);
    n_beats = (kind < 2) ? $urandom_range(60, 70) : $urandom_range(1, 30);
    ended   = 1'b0;
    for (i = 0; i < n_beats && !ended; i++) begin
      case (kind)
        0:       step = '0;
        1:       step = $urandom_range(0, 3);
        2:       step = $urandom_range(32'h4000_0000, 32'hC000_0000);
        default: step = pick_interval();
      endcase
      t       = t + step;
      elapsed = t - t0;
      ended   = (elapsed >= window_setting);
      send_item(FN_BEAT, t);
      if (!ended && $urandom_range(0, 39) == 0) begin
        send_item(FN_CANCEL, $urandom());
        ended = 1'b1;
      end
    end
    if (!ended) begin
      case ($urandom_range(0, 7))
        0, 1: send_item(FN_CANCEL, $urandom());
        2: ;
        3: begin
          if (window_setting != 0) send_item(FN_BEAT, t0 + window_setting - 1);
          send_item(FN_BEAT, t0 + window_setting);
        end
        default: send_item(FN_BEAT, t0 + window_setting);
      endcase
    end
  endtask

  // Random commands with random stamps; mostly ignored, so not counted
  task automatic noise_session();
    int n;
    int i;
    int keep;
    keep = items_sent;
    n    = $urandom_range(2, 10);
    for (i = 0; i < n; i++) send_item(func_e'($urandom_range(0, 3)), $urandom());
    items_sent = keep;
  endtask

  // Output side back-pressure
  initial begin
    int run_len;
    int gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      out_ready_i <= 1'b1;
      run_len = $urandom_range(1, 24);
      repeat (run_len) @(posedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  // Beat monitor on both channels, plus the stall watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_reading(out_data_o);
      if (in_valid_i && in_ready_o) sb.note_item(in_data_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stalled_cycles = 0;
      else stalled_cycles++;
      if (stalled_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] windows [N_PHASES];
    int          p;
    windows = '{WINDOW_RST, 32'd0, 32'hFFFF_FFFF, 32'd3000,
                32'($urandom_range(1000, 60000)), 32'd1, 32'($urandom()), WINDOW_RST};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: ignored commands, zero anchor, window edge, wrap, empty run
    send_item(FN_BEAT,   32'hFFFF_FFFF);
    send_item(FN_CANCEL, 32'h0);
    send_item(FN_START,  32'h0);
    send_item(FN_START,  32'h1234_5678);
    send_item(FN_BEAT,   32'd0);
    send_item(FN_BEAT,   32'd800);
    send_item(FN_BEAT,   32'd1600);
    send_item(FN_BEAT,   32'd1600);
    send_item(FN_BEAT,   32'd14999);
    send_item(FN_BEAT,   32'd15000);
    send_item(FN_BEAT,   32'd16000);
    send_item(FN_CANCEL, 32'h0);
    send_item(FN_START,  32'h0);
    send_item(FN_RESET,  32'hFFFF_FFFF);
    send_item(FN_START,  32'h0);
    send_item(FN_BEAT,   32'hFFFF_FF00);
    send_item(FN_BEAT,   32'h0000_0100);
    send_item(FN_CANCEL, 32'h0);
    send_item(FN_BEAT,   32'h0000_0200);
    send_item(FN_RESET,  32'h0);
    send_item(FN_START,  32'h0);
    send_item(FN_BEAT,   32'd5);
    send_item(FN_BEAT,   32'd20000);
    send_item(FN_RESET,  32'h0);

    // Random runs, one window setting per phase
    items_sent = 0;
    for (p = 0; p < N_PHASES; p++) begin
      if (p > 0) set_window(windows[p]);
      no_gaps = ($urandom_range(0, 3) == 0);
      while (items_sent < (RANDOM_ITEMS * (p + 1)) / N_PHASES) begin
        if ($urandom_range(0, 7) == 0) noise_session();
        else beat_session();
      end
    end

    drain();
    if (sb.n_errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ windowed_heart_rate_average.f @@
rtl/whra_pkg.sv
rtl/windowed_heart_rate_average.sv
bench/tb_top.sv
